>>> design/gmm_pkg.sv
// shared types, constants and helper functions of the grayscale min/max filter
package gmm_pkg;

  localparam int PIX_W      = 8;
  localparam int DIM_W      = 11;
  localparam int RAD_CFG_W  = 2;
  localparam int RAD_W      = 3;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 11;
  localparam int HEIGHT_CAP = 1024;
  localparam int ROW_W      = 10;

  typedef logic [PIX_W-1:0] pix_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 8'd0,
    REG_IMAGE_HEIGHT = 8'd1,
    REG_WINDOW_RAD   = 8'd2,
    REG_FILTER_MODE  = 8'd3
  } cfg_reg_t;

  // input operation codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_PAD   = 1'b1;

  // filter mode codes
  localparam logic MODE_ERODE  = 1'b0;
  localparam logic MODE_DILATE = 1'b1;

  // per-item control carried down the pipeline
  typedef struct packed {
    logic emit;
    logic border;
    logic last;
  } item_flags_t;

  // control shared by every cell of the chain
  typedef struct packed {
    logic             re;
    logic             we;
    logic             hit;
    logic             shift;
    logic             load_red;
    logic             mode;
    logic [RAD_W-1:0] radius;
  } cell_ctrl_t;

  // one entry of the output buffer
  typedef struct packed {
    pix_t value;
    logic last;
  } res_item_t;

  // value that never wins the reduction
  function automatic pix_t gmm_neutral(input logic mode);
    return (mode == MODE_DILATE) ? '0 : '1;
  endfunction

  // pairwise minimum or maximum
  function automatic pix_t gmm_pick(input logic mode, input pix_t a, input pix_t b);
    pix_t res;
    if (mode == MODE_DILATE) begin
      res = (b > a) ? b : a;
    end else begin
      res = (b < a) ? b : a;
    end
    return res;
  endfunction

endpackage

>>> design/gmm_pix_if.sv
// pixel input channel
interface gmm_pix_if;
  import gmm_pkg::*;

  logic valid;
  logic ready;
  logic operation;
  pix_t pixel_value;

  modport source (output valid, output operation, output pixel_value, input ready);
  modport sink (input valid, input operation, input pixel_value, output ready);
endinterface

>>> design/gmm_res_if.sv
// filtered pixel output channel
interface gmm_res_if;
  import gmm_pkg::*;

  logic valid;
  logic ready;
  pix_t result_value;
  logic frame_last;

  modport source (output valid, output result_value, output frame_last, input ready);
  modport sink (input valid, input result_value, input frame_last, output ready);
endinterface

>>> design/gmm_cfg_if.sv
// configuration write channel
interface gmm_cfg_if;
  import gmm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/gmm_ram.sv
// generic single write port ram with registered read
module gmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/gmm_cell.sv
// one window row: line delay to the next row and a column shift line with row reduction
module gmm_cell #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 3,
  parameter int IDX        = 0,
  parameter bit LINE_EN    = 1'b1
) (
  input  logic                         clk,
  input  gmm_pkg::cell_ctrl_t          ctrl,
  input  logic [$clog2(MAX_WIDTH)-1:0] raddr,
  input  logic [$clog2(MAX_WIDTH)-1:0] waddr,
  input  gmm_pkg::pix_t                in_val,
  output gmm_pkg::pix_t                out_val,
  output gmm_pkg::pix_t                row_red
);
  import gmm_pkg::*;

  localparam int TAPS = 2 * MAX_RADIUS + 1;

  pix_t             taps [TAPS];
  pix_t             red;
  logic [RAD_W:0]   span;

  // column shift line, one step per transaction leaving the first stage
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      taps[0] <= in_val;
      for (int i = 1; i < TAPS; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  // line delay feeding the row one line older
  if (LINE_EN) begin : g_line
    pix_t ram_rd;

    gmm_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk   (clk),
      .we    (ctrl.we),
      .waddr (waddr),
      .wdata (in_val),
      .re    (ctrl.re),
      .raddr (raddr),
      .rdata (ram_rd)
    );

    // bypass when the read raced the write of the previous column at the same address
    assign out_val = ctrl.hit ? taps[0] : ram_rd;
  end else begin : g_no_line
    assign out_val = '0;
  end

  // reduction over the active columns of this row, neutral when this row lies outside the window
  always_comb begin
    span = {ctrl.radius, 1'b0};
    red  = gmm_neutral(ctrl.mode);
    for (int i = 0; i < TAPS; i++) begin
      if ((RAD_W+1)'(i) <= span) begin
        red = gmm_pick(ctrl.mode, red, taps[i]);
      end
    end
    if ((RAD_W+1)'(IDX) > span) begin
      red = gmm_neutral(ctrl.mode);
    end
  end

  // registered row result
  always_ff @(posedge clk) begin
    if (ctrl.load_red) begin
      row_red <= red;
    end
  end

endmodule

>>> design/grayscale_morphology_minmax_filter.sv
// top level of the grayscale erosion / dilation filter over a square window
// Takes one pixel per clock in raster order and gives, for every frame position, the minimum
// (erosion) or maximum (dilation) of the (2r+1) x (2r+1) window around it, 0 within r of an
// edge. A transaction is taken every clock while the two-entry output buffer has room; the
// first result of a frame follows r lines plus r pixels of input, and each result leaves the
// four-stage pipeline (line ram read, column shift, row reduction, window reduction) into the
// output buffer. The window is a chain of 2*MAX_RADIUS+1 row cells, each but the last with a
// line ram of MAX_WIDTH entries feeding the next row. The line rams need no clearing pass:
// positions whose window would reach unwritten lines are border positions and give 0.
// Padding items take a raster position as a zero pixel inside the frame and flush the tail
// after it. Writing a known register restarts the frame; write only while the block is idle.
module grayscale_morphology_minmax_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 3
) (
  input  logic      clk,
  input  logic      rst,
  gmm_pix_if.sink   pixels,
  gmm_res_if.source results,
  gmm_cfg_if.sink   cfg
);
  import gmm_pkg::*;

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int EW   = (WW > DIM_W) ? WW : DIM_W;
  localparam int LW   = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
  localparam int TAPS = 2 * MAX_RADIUS + 1;

  // configuration registers
  logic [DIM_W-1:0]     image_width;
  logic [DIM_W-1:0]     image_height;
  logic [RAD_CFG_W-1:0] window_radius;
  logic                 filter_mode;

  // effective settings
  logic [EW-1:0]    width_ext;
  logic [EW-1:0]    eff_w;
  logic [DIM_W-1:0] eff_h;
  logic [RAD_W-1:0] eff_r;
  logic [LW-1:0]    lag;

  // raster counters
  logic [AW-1:0]    input_column;
  logic [LW-1:0]    lead_count;
  logic [AW-1:0]    out_col;
  logic [ROW_W-1:0] out_row;

  // handshakes
  logic cfg_write;
  logic cfg_hit;
  logic accept;
  logic en;

  // item flags at the input
  logic        emit;
  logic        col_last;
  logic        frame_end;
  logic        interior;
  item_flags_t in_flags;
  logic        hit;

  // pipeline
  logic        s1_valid;
  pix_t        s1_pixel;
  logic [AW-1:0] s1_col;
  logic        s1_hit;
  item_flags_t s1_flags;
  logic        s2_valid;
  item_flags_t s2_flags;
  logic        s3_valid;
  item_flags_t s3_flags;

  // cell chain
  cell_ctrl_t ctrl;
  pix_t       chain   [TAPS];
  pix_t       row_red [TAPS];
  pix_t       window_val;

  // output buffer
  res_item_t  fifo_head;
  res_item_t  fifo_tail;
  res_item_t  push_item;
  logic [1:0] fifo_count;
  logic       push;
  logic       pop;

  // handshake decode
  assign cfg.ready     = 1'b1;
  assign cfg_write     = cfg.valid && cfg.ready;
  assign en            = (fifo_count != 2'd2);
  assign pixels.ready  = en;
  assign accept        = pixels.valid && pixels.ready;

  always_comb begin
    case (cfg.index)
      REG_IMAGE_WIDTH,
      REG_IMAGE_HEIGHT,
      REG_WINDOW_RAD,
      REG_FILTER_MODE: cfg_hit = 1'b1;
      default:         cfg_hit = 1'b0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= DIM_W'(640);
      image_height  <= DIM_W'(480);
      window_radius <= RAD_CFG_W'(1);
      filter_mode   <= MODE_ERODE;
    end else if (cfg_write) begin
      case (cfg.index)
        REG_IMAGE_WIDTH:  image_width   <= cfg.data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height  <= cfg.data[DIM_W-1:0];
        REG_WINDOW_RAD:   window_radius <= cfg.data[RAD_CFG_W-1:0];
        REG_FILTER_MODE:  filter_mode   <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // clamp settings into range
  always_comb begin
    width_ext = EW'(image_width);
    if (width_ext == '0) begin
      eff_w = EW'(1);
    end else if (width_ext > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = width_ext;
    end
    if (image_height == '0) begin
      eff_h = DIM_W'(1);
    end else if (image_height > DIM_W'(HEIGHT_CAP)) begin
      eff_h = DIM_W'(HEIGHT_CAP);
    end else begin
      eff_h = image_height;
    end
    if (RAD_W'(window_radius) > RAD_W'(MAX_RADIUS)) begin
      eff_r = RAD_W'(MAX_RADIUS);
    end else begin
      eff_r = RAD_W'(window_radius);
    end
    lag = LW'(eff_r) * LW'(eff_w) + LW'(eff_r);
  end

  // flags of the incoming transaction
  always_comb begin
    emit      = (lead_count == lag);
    col_last  = (EW'(input_column) == eff_w - EW'(1));
    frame_end = emit && (EW'(out_col) == eff_w - EW'(1))
                     && (DIM_W'(out_row) == eff_h - DIM_W'(1));
    interior  = (DIM_W'(out_row) >= DIM_W'(eff_r))
             && (DIM_W'(out_row) + DIM_W'(eff_r) < eff_h)
             && (EW'(out_col) >= EW'(eff_r))
             && (EW'(out_col) + EW'(eff_r) < eff_w);
    in_flags.emit   = emit;
    in_flags.border = !interior;
    in_flags.last   = frame_end;
    hit = s1_valid && (s1_col == input_column);
  end

  // raster counters
  always_ff @(posedge clk) begin
    if (rst || cfg_write && cfg_hit) begin
      input_column <= '0;
      lead_count   <= '0;
      out_col      <= '0;
      out_row      <= '0;
    end else if (accept) begin
      if (frame_end) begin
        input_column <= '0;
        lead_count   <= '0;
        out_col      <= '0;
        out_row      <= '0;
      end else begin
        input_column <= col_last ? '0 : input_column + AW'(1);
        if (emit) begin
          if (EW'(out_col) == eff_w - EW'(1)) begin
            out_col <= '0;
            out_row <= out_row + ROW_W'(1);
          end else begin
            out_col <= out_col + AW'(1);
          end
        end else begin
          lead_count <= lead_count + LW'(1);
        end
      end
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= (pixels.operation == OP_PAD) ? '0 : pixels.pixel_value;
      s1_col   <= input_column;
      s1_hit   <= hit;
      s1_flags <= in_flags;
    end
    if (en) begin
      s2_flags <= s1_flags;
      s3_flags <= s2_flags;
    end
  end

  // cell control
  always_comb begin
    ctrl.re       = accept;
    ctrl.we       = en && s1_valid;
    ctrl.hit      = s1_hit;
    ctrl.shift    = en && s1_valid;
    ctrl.load_red = en && s2_valid;
    ctrl.mode     = filter_mode;
    ctrl.radius   = eff_r;
  end

  assign chain[0] = s1_pixel;

  // chain of row cells, newest row first
  for (genvar j = 0; j < TAPS; j++) begin : g_cell
    if (j < TAPS - 1) begin : g_mid
      gmm_cell #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS),
        .IDX        (j),
        .LINE_EN    (1'b1)
      ) u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .raddr   (input_column),
        .waddr   (s1_col),
        .in_val  (chain[j]),
        .out_val (chain[j+1]),
        .row_red (row_red[j])
      );
    end else begin : g_end
      gmm_cell #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS),
        .IDX        (j),
        .LINE_EN    (1'b0)
      ) u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .raddr   (input_column),
        .waddr   (s1_col),
        .in_val  (chain[j]),
        .out_val (),
        .row_red (row_red[j])
      );
    end
  end

  // reduction across rows and border masking
  always_comb begin
    window_val = gmm_neutral(filter_mode);
    for (int j = 0; j < TAPS; j++) begin
      window_val = gmm_pick(filter_mode, window_val, row_red[j]);
    end
    push_item.value = s3_flags.border ? '0 : window_val;
    push_item.last  = s3_flags.last;
    push = en && s3_valid && s3_flags.emit;
  end

  // two-entry output buffer
  assign pop                  = results.valid && results.ready;
  assign results.valid        = (fifo_count != 2'd0);
  assign results.result_value = fifo_head.value;
  assign results.frame_last   = fifo_head.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_count <= 2'd0;
    end else if (push && !pop) begin
      fifo_count <= fifo_count + 2'd1;
    end else if (pop && !push) begin
      fifo_count <= fifo_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (fifo_count == 2'd0) begin
        fifo_head <= push_item;
      end else begin
        fifo_tail <= push_item;
      end
    end else if (pop && !push) begin
      fifo_head <= fifo_tail;
    end else if (push && pop) begin
      if (fifo_count == 2'd1) begin
        fifo_head <= push_item;
      end else begin
        fifo_head <= fifo_tail;
        fifo_tail <= push_item;
      end
    end
  end

  // counters return to the frame start after the final result
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    accept && frame_end && !cfg_write |=> input_column == '0 && lead_count == '0
                                        && out_col == '0 && out_row == '0)
    else $error("counters not cleared at end of frame");

  // raster columns stay inside the effective width
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    EW'(input_column) < eff_w && EW'(out_col) < eff_w)
    else $error("column counter beyond image width");

  // the lead counter never passes the lag
  a_lead_bound: assert property (@(posedge clk) disable iff (rst)
    lead_count <= lag)
    else $error("lead counter beyond lag");

  // the output buffer never overflows
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count == 2'd2 |-> !push)
    else $error("push into full output buffer");

endmodule

>>> tb/sv/gmm_minmax_checker.sv
// checker of the grayscale min/max filter: predicts every filtered pixel and compares
module gmm_minmax_checker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 3
) (
  input  logic clk,
  input  logic rst,
  gmm_pix_if   pixels,
  gmm_res_if   results,
  gmm_cfg_if   cfg,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import gmm_pkg::*;

  localparam int STORE_ROWS = 2 * MAX_RADIUS + 1;
  localparam int unsigned ROW_SATURATE = (1 << DIM_W) - 1;
  localparam int unsigned COUNT_MASK = (1 << 20) - 1;

  // mirrored registers
  logic [DIM_W-1:0]     width_reg;
  logic [DIM_W-1:0]     height_reg;
  logic [RAD_CFG_W-1:0] radius_reg;
  logic                 mode_reg;

  // mirrored line memory and raster counters
  pix_t        line_mem [STORE_ROWS][MAX_WIDTH];
  int unsigned in_col;
  int unsigned in_row;
  int unsigned out_idx;

  // filtered pixels still to come, oldest first
  res_item_t expected_pixels [$];

  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    if (height_reg == 0) return 1;
    if (height_reg > HEIGHT_CAP) return HEIGHT_CAP;
    return height_reg;
  endfunction

  function automatic int unsigned active_radius();
    if (radius_reg > MAX_RADIUS) return MAX_RADIUS;
    return radius_reg;
  endfunction

  function automatic void restart_raster();
    in_col  = 0;
    in_row  = 0;
    out_idx = 0;
  endfunction

  // takes one input pixel; returns 1 when it releases a filtered pixel
  function automatic bit predict_window_extreme(input logic op, input pix_t px,
                                                output res_item_t res);
    int unsigned w, h, r, pos, lag, orow, ocol, dy, dx;
    pix_t best;
    pix_t v;
    w = active_width();
    h = active_height();
    r = active_radius();
    res = '0;

    // store the pixel while it lies inside the frame
    if (in_row < h && in_col < w) begin
      line_mem[in_row % STORE_ROWS][in_col] = (op == OP_PAD) ? pix_t'(0) : px;
    end
    pos = in_row * w + in_col;
    lag = r * w + r;

    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      if (in_row < ROW_SATURATE) in_row++;
    end
    if (pos < lag) return 0;

    // reduce the window unless it reaches over an edge
    orow = out_idx / w;
    ocol = out_idx % w;
    best = '0;
    if (orow >= r && orow + r < h && ocol >= r && ocol + r < w) begin
      best = (mode_reg == MODE_DILATE) ? pix_t'(0) : pix_t'(255);
      for (dy = 0; dy < 2 * r + 1; dy++) begin
        for (dx = 0; dx < 2 * r + 1; dx++) begin
          v = line_mem[(orow - r + dy) % STORE_ROWS][ocol - r + dx];
          if (mode_reg == MODE_DILATE ? (v > best) : (v < best)) best = v;
        end
      end
    end

    res.value = best;
    res.last  = (out_idx + 1 >= w * h);
    if (res.last) begin
      restart_raster();
    end else begin
      out_idx = (out_idx + 1) & COUNT_MASK;
    end
    return 1;
  endfunction

  // watch the three channels at every rising edge
  always @(posedge clk) begin : track
    res_item_t want;
    res_item_t got;
    logic      known;
    if (rst) begin
      width_reg  = 640;
      height_reg = 480;
      radius_reg = 1;
      mode_reg   = MODE_ERODE;
      restart_raster();
      expected_pixels.delete();
    end else begin
      // compare a result transaction with the oldest expectation
      if (results.valid && results.ready) begin
        got.value = results.result_value;
        got.last  = results.frame_last;
        if (expected_pixels.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, value %0d frame_last %0b",
                   $time, got.value, got.last);
        end else begin
          want = expected_pixels.pop_front();
          if (got.value !== want.value) begin
            errors++;
            $display("%0t: result_value mismatch, expected %0d, got %0d",
                     $time, want.value, got.value);
          end
          if (got.last !== want.last) begin
            errors++;
            $display("%0t: frame_last mismatch, expected %0b, got %0b",
                     $time, want.last, got.last);
          end
        end
      end

      // register write; a known index restarts the frame
      if (cfg.valid && cfg.ready) begin
        known = 1'b1;
        case (cfg.index)
          REG_IMAGE_WIDTH:  width_reg  = cfg.data[DIM_W-1:0];
          REG_IMAGE_HEIGHT: height_reg = cfg.data[DIM_W-1:0];
          REG_WINDOW_RAD:   radius_reg = cfg.data[RAD_CFG_W-1:0];
          REG_FILTER_MODE:  mode_reg   = cfg.data[0];
          default:          known      = 1'b0;
        endcase
        if (known) restart_raster();
      end

      // pixel transaction
      if (pixels.valid && pixels.ready) begin
        if (predict_window_extreme(pixels.operation, pixels.pixel_value, want)) begin
          expected_pixels.push_back(want);
        end
      end
    end
    pending = expected_pixels.size();
  end

endmodule

>>> tb/sv/grayscale_morphology_minmax_filter_tb.sv
// stimulus and verdict for the grayscale min/max filter, checked by gmm_minmax_checker
module grayscale_morphology_minmax_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gmm_pkg::*;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_RADIUS    = 3;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 650;
  localparam int CYCLE_LIMIT   = 900000;

  logic clk;
  logic rst;
  int   errors;
  int   pending_results;
  int   cycle_count;

  gmm_pix_if pix_ch ();
  gmm_res_if res_ch ();
  gmm_cfg_if cfg_ch ();

  grayscale_morphology_minmax_filter #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIUS(MAX_RADIUS)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .pixels (pix_ch),
    .results(res_ch),
    .cfg    (cfg_ch)
  );

  gmm_minmax_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIUS(MAX_RADIUS)
  ) chk (
    .clk    (clk),
    .rst    (rst),
    .pixels (pix_ch),
    .results(res_ch),
    .cfg    (cfg_ch),
    .errors (errors),
    .pending(pending_results)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stalls on segments of varying style
  int unsigned stall_style;
  int unsigned stall_left;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_style)
      0:       res_ch.ready <= 1'b1;
      1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
      2:       res_ch.ready <= $urandom_range(0, 1);
      default: res_ch.ready <= ((stall_left % 9) > 5);
    endcase
  end

  // stimulus-side view of the configuration
  int unsigned frame_w;
  int unsigned frame_h;
  int unsigned frame_r;
  int unsigned burst_left;
  int unsigned random_items;

  function automatic int unsigned clamp_dim(input int unsigned raw, input int unsigned cap);
    if (raw == 0) return 1;
    if (raw > cap) return cap;
    return raw;
  endfunction

  function automatic pix_t pick_pixel();
    case ($urandom_range(0, 7))
      0:       return pix_t'(0);
      1:       return pix_t'(255);
      default: return pix_t'($urandom);
    endcase
  endfunction

  // one pixel transaction; valid stays high between items of a burst
  task automatic send_item(input logic op, input pix_t v);
    if (burst_left == 0) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.operation   <= op;
    pix_ch.pixel_value <= v;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  // hold the sender until every expected result has come and the pipeline is empty
  task automatic drain_results();
    pix_ch.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input int unsigned w, input int unsigned h,
                           input int unsigned r, input logic mode);
    drain_results();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_WINDOW_RAD, r);
    write_reg(REG_FILTER_MODE, mode);
    frame_w = clamp_dim(w, MAX_WIDTH);
    frame_h = clamp_dim(h, HEIGHT_CAP);
    frame_r = r;
  endtask

  // one frame of pixels, then enough flush items to bring out its last result
  task automatic send_frame(input int unsigned pad_pct, input bit counted);
    int unsigned pixels_n, total, pause_at, i;
    logic op;
    pixels_n = frame_w * frame_h;
    total    = pixels_n + frame_r * frame_w + frame_r;
    pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1) : total;
    for (i = 0; i < total; i++) begin
      if (i == pause_at) drain_results();
      if (i < pixels_n) begin
        op = ($urandom_range(0, 99) < pad_pct) ? OP_PAD : OP_PIXEL;
      end else begin
        op = $urandom_range(0, 1) ? OP_PAD : OP_PIXEL;
      end
      send_item(op, pick_pixel());
    end
    if (counted) random_items += total;
  endtask

  // stimulus
  initial begin : stimulus
    pix_t        seed_frame [16];
    int unsigned i, w, h, n;
    rst                = 1'b1;
    pix_ch.valid       = 1'b0;
    pix_ch.operation   = OP_PIXEL;
    pix_ch.pixel_value = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_IMAGE_WIDTH;
    cfg_ch.data        = '0;
    res_ch.ready       = 1'b0;
    cycle_count        = 0;
    stall_left         = 0;
    burst_left         = 0;
    random_items       = 0;
    seed_frame = '{8'd0, 8'd255, 8'hAA, 8'h55,
                   8'd255, 8'd255, 8'd255, 8'd255,
                   8'd1, 8'd254, 8'd255, 8'd128,
                   8'd127, 8'd255, 8'd0, 8'd255};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed 4x4 erosion frame with extreme values and padding inside the frame
    configure(4, 4, 1, MODE_ERODE);
    for (i = 0; i < 16; i++) begin
      send_item((i == 6) ? OP_PAD : OP_PIXEL, seed_frame[i]);
    end
    for (i = 0; i < 5; i++) begin
      send_item((i % 2) ? OP_PAD : OP_PIXEL, pix_t'(255));
    end

    // zero sizes act as one; lag longer than the frame
    configure(0, 0, 3, MODE_DILATE);
    repeat (3) send_frame(0, 1'b0);

    // width above the maximum, single line
    configure({DIM_W{1'b1}}, 1, 0, MODE_ERODE);
    send_frame(10, 1'b0);

    // height above the cap, single column
    configure(1, {DIM_W{1'b1}}, 0, MODE_DILATE);
    send_frame(10, 1'b0);

    // full-width lines with a real window
    configure(MAX_WIDTH, 3, 1, MODE_DILATE);
    send_frame(5, 1'b0);

    // window wider than the frame
    configure(2, 9, 3, MODE_ERODE);
    send_frame(0, 1'b0);

    // a write to an unknown register leaves the frame running
    configure(5, 5, 1, MODE_DILATE);
    drain_results();
    write_reg($urandom_range(REG_FILTER_MODE + 1, {CFG_IDX_W{1'b1}}), $urandom);
    send_frame(0, 1'b0);

    // random settings, mostly complete frames, some abandoned part way
    while (random_items < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      h = $urandom_range(1, 12);
      configure(w, h, $urandom_range(0, 3), $urandom_range(0, 1));
      if ($urandom_range(0, 4) == 0) begin
        write_reg($urandom_range(REG_FILTER_MODE + 1, {CFG_IDX_W{1'b1}}), $urandom);
      end
      repeat ($urandom_range(1, 3)) send_frame($urandom_range(0, 1) ? 0 : 15, 1'b1);
      if ($urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, frame_w * frame_h);
        for (i = 0; i < n; i++) send_item(OP_PIXEL, pick_pixel());
        random_items += n;
      end
    end

    // wait for the tail, then give the verdict
    drain_results();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
